>>> rtl/fm_two_operator_voice_defines.svh
// ----------------------------------------------------------------------------
// FM voice assertion macros
// Shared concurrent assertion forms used by the FM voice RTL.
// ----------------------------------------------------------------------------
`ifndef FM_TWO_OPERATOR_VOICE_DEFINES_SVH
`define FM_TWO_OPERATOR_VOICE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fmv_pkg.sv
// ----------------------------------------------------------------------------
// FM voice package
// Widths, codes, structs and the elaboration-time table builders.
// ----------------------------------------------------------------------------
package fmv_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int SINE_DEPTH  = 1024;
    localparam int SAMPLE_RATE = 44100;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int MAG_W       = PHASE_BITS - 2;
    localparam int NOTE_W      = 7;
    localparam int NUM_NOTES   = 128;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int RATIO_FRAC  = 8;
    localparam int INDEX_FRAC  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MOD_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_INDEX = 1'd1;

    localparam logic [CFG_W-1:0] MOD_RATIO_RESET = 16'd256;
    localparam logic [CFG_W-1:0] MOD_INDEX_RESET = 16'd4096;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_RELEASE = 2'd2,
        OP_END     = 2'd3
    } t_op;

    typedef logic [PHASE_BITS-1:0] t_phase;

    // Live voice state seen by the sample datapath.
    typedef struct packed {
        logic              playing;
        t_phase            cphase;
        t_phase            mphase;
        logic [CFG_W-1:0]  mod_index;
    } t_voice;

    // Load strobes of the three pipeline registers.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ld;

    // Second stage contents: rounded phase offset and carrier phase.
    typedef struct packed {
        logic   play;
        logic   neg;
        t_phase off;
        t_phase cph;
    } t_stage2;

    typedef logic [NUM_NOTES-1:0][PHASE_BITS-1:0] t_step_tab;
    typedef logic [SINE_DEPTH-1:0][SAMPLE_W-1:0]  t_ctab;
    typedef logic [SINE_DEPTH-1:0][MAG_W:0]       t_mtab;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q40 = 64'd1727108826179;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint unsigned C_MAX       = 64'd32767;

    // Top octave (notes 120 to 131) in Hz, unsigned Q16.16.
    localparam longint unsigned TOP_OCTAVE_Q16 [12] = '{
        64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
        64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
        64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
    };

    // Sine of a Q30 angle in the first quadrant, Horner form of the series.
    function automatic longint unsigned sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
        return (x * t) >> 30;
    endfunction

    // Carrier phase step of every note, wrapped to one turn. The rounded
    // division by the sample rate times a power of two is done as a rounded
    // division by the sample rate followed by a right shift.
    function automatic t_step_tab build_step_tab();
        t_step_tab       tab;
        longint unsigned num;
        longint unsigned q;
        int              n;
        int              oct;
        int              cls;
        int              sh;
        tab = '0;
        for (oct = 0; oct * 12 < NUM_NOTES; oct++) begin
            for (cls = 0; cls < 12; cls++) begin
                n = oct * 12 + cls;
                if (n < NUM_NOTES) begin
                    sh     = 26 - oct;
                    num    = TOP_OCTAVE_Q16[cls] << PHASE_BITS;
                    q      = ((num + (longint'(SAMPLE_RATE) << (sh - 1))) / SAMPLE_RATE)
                             >> sh;
                    tab[n] = q[PHASE_BITS-1:0];
                end
            end
        end
        return tab;
    endfunction

    // Quadrant-folded Q30 sine magnitude of table entry i.
    function automatic longint unsigned entry_sine(input int i);
        longint unsigned m;
        longint unsigned r;
        longint unsigned d;
        longint unsigned ang;
        d = longint'(SINE_DEPTH);
        m = 4 * longint'(i);
        if (m <= d) begin
            r = m;
        end else if (m <= 2 * d) begin
            r = 2 * d - m;
        end else if (m <= 3 * d) begin
            r = m - 2 * d;
        end else begin
            r = 4 * d - m;
        end
        ang = ((r * HALF_PI_Q40) / SINE_DEPTH + 64'd512) >> 10;
        return sine_q30(ang);
    endfunction

    // Carrier sine table, signed Q1.15.
    function automatic t_ctab build_ctab();
        t_ctab                tab;
        longint unsigned      s;
        longint unsigned      c;
        logic [SAMPLE_W-1:0]  c16;
        logic                 neg;
        int                   i;
        for (i = 0; i < SINE_DEPTH; i++) begin
            s   = entry_sine(i);
            neg = (4 * i > 2 * SINE_DEPTH);
            c   = (s + 64'd16384) >> 15;
            if (c > C_MAX) begin
                c = C_MAX;
            end
            c16    = c[SAMPLE_W-1:0];
            tab[i] = neg ? (SAMPLE_W'(0) - c16) : c16;
        end
        return tab;
    endfunction

    // Modulator sine table in phase units, stored as sign and magnitude.
    function automatic t_mtab build_mtab();
        t_mtab           tab;
        longint unsigned s;
        longint unsigned p;
        logic            neg;
        int              i;
        for (i = 0; i < SINE_DEPTH; i++) begin
            s      = entry_sine(i);
            neg    = (4 * i > 2 * SINE_DEPTH);
            p      = ((s << PHASE_BITS) + TWO_PI_Q30 / 2) / TWO_PI_Q30;
            tab[i] = {neg, p[MAG_W-1:0]};
        end
        return tab;
    endfunction

endpackage

>>> rtl/fm_two_operator_voice.sv
// ----------------------------------------------------------------------------
// Two-operator FM voice: a tick's sample is registered through the modulator,
// scaling and carrier stages; one item per cycle is accepted unless stalled.
// Synchronous active-low reset stops the voice, zeroes phases and steps and
// loads the default ratio and index; the sine tables are constants.
// ----------------------------------------------------------------------------
`include "fm_two_operator_voice_defines.svh"

module fm_two_operator_voice import fmv_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // Command channel.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_op,
    input  logic [NOTE_W-1:0]           i_note,
    // Sample channel.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    // The voice state (phases, steps, play flag) lives in the control block
    // and is updated in the cycle of the transfer, so a tick in every cycle
    // keeps the phase accumulators running at full rate. Each tick that has
    // a result carries a copy of the phases into a three-register pipeline:
    //   stage 1: modulator sine read at the modulator phase,
    //   stage 2: scaling by the modulation index (one 22x16 multiply),
    //   stage 3: carrier phase plus offset, carrier sine read, output register.
    // Note on, release and end produce no sample and do not enter the pipeline.
    //
    // Each stage has its own valid bit and loads whenever the stage after it
    // is empty or moving on, so bubbles collapse and new commands are taken
    // while a finished sample waits at the output.

    t_op        w_op;
    logic       w_accept;
    logic       w_free1;
    logic       w_free2;
    logic       w_free3;
    t_pipe_ld   w_ld;
    t_voice     w_voice;
    t_stage2    w_s2;

    logic       r_v1;
    logic       r_v2;
    logic       r_v3;

    logic [SAMPLE_W-1:0] w_sample;

    assign w_op = t_op'(i_op);

    // Backpressure runs from the output register toward the input.
    always_comb begin
        w_free3  = !r_v3 || !i_out_stall;
        w_free2  = !r_v2 || w_free3;
        w_free1  = !r_v1 || w_free2;
        w_accept = i_in_valid && w_free1;
        w_ld.ld1 = w_accept && (w_op == OP_TICK);
        w_ld.ld2 = r_v1 && w_free2;
        w_ld.ld3 = r_v2 && w_free3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_ld.ld1 || (r_v1 && !w_free2);
            r_v2 <= w_ld.ld2 || (r_v2 && !w_free3);
            r_v3 <= w_ld.ld3 || (r_v3 && i_out_stall);
        end
    end

    fmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_op        (w_op),
        .i_note      (i_note),
        .o_voice     (w_voice)
    );

    fmv_offset u_offset (
        .i_clk   (i_clk),
        .i_ld    (w_ld),
        .i_voice (w_voice),
        .o_s2    (w_s2)
    );

    fmv_carrier u_carrier (
        .i_clk    (i_clk),
        .i_ld     (w_ld),
        .i_s2     (w_s2),
        .o_sample (w_sample)
    );

    assign o_in_stall  = !w_free1;
    assign o_out_valid = r_v3;
    assign o_sample    = signed'(w_sample);

    // A note on always leaves the voice playing.
    `FMV_ASSERT_NEXT(a_note_on_plays, i_clk, i_rst_n, w_accept && (w_op == OP_NOTE_ON), w_voice.playing, "note on did not start the voice")
    // Release and end always stop the voice.
    `FMV_ASSERT_NEXT(a_stop_cmd, i_clk, i_rst_n, w_accept && (w_op == OP_RELEASE || w_op == OP_END), !w_voice.playing, "release or end did not stop the voice")
    // A tick on a stopped voice leaves both phases where they were.
    `FMV_ASSERT_NEXT(a_idle_tick_hold, i_clk, i_rst_n, w_accept && (w_op == OP_TICK) && !w_voice.playing, $stable(w_voice.cphase) && $stable(w_voice.mphase), "phase moved on a stopped tick")
    // With every stage full and the output held, no command may enter.
    `FMV_ASSERT_SAME(a_full_stalls, i_clk, i_rst_n, r_v1 && r_v2 && r_v3 && i_out_stall, o_in_stall, "command taken into a full pipeline")

endmodule

>>> rtl/fmv_ctrl.sv
// ----------------------------------------------------------------------------
// FM voice control
// Configuration registers, note tuning, phase accumulators and play state.
// ----------------------------------------------------------------------------
module fmv_ctrl import fmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_accept,
    input  t_op                   i_op,
    input  logic [NOTE_W-1:0]     i_note,
    output t_voice                o_voice
);

    localparam int        MPROD_W     = PHASE_BITS + CFG_W;
    localparam t_step_tab STEP_TAB    = build_step_tab();
    localparam logic [MPROD_W-1:0] RATIO_ROUND = MPROD_W'(1) << (RATIO_FRAC - 1);

    logic [CFG_W-1:0]    r_mod_ratio;
    logic [CFG_W-1:0]    r_mod_index;
    t_phase              r_cstep;
    t_phase              r_mstep;
    t_phase              r_cphase;
    t_phase              r_mphase;
    logic                r_playing;

    t_phase              n_cstep;
    t_phase              n_mstep;
    logic [MPROD_W-1:0]  w_mprod;
    logic [MPROD_W-1:0]  w_mround;

    // Modulator step is the carrier step scaled by the ratio, saturated to one turn.
    always_comb begin
        n_cstep  = STEP_TAB[i_note];
        w_mprod  = MPROD_W'(n_cstep) * MPROD_W'(r_mod_ratio);
        w_mround = (w_mprod + RATIO_ROUND) >> RATIO_FRAC;
        if (|w_mround[MPROD_W-1:PHASE_BITS]) begin
            n_mstep = '1;
        end else begin
            n_mstep = w_mround[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_ratio <= MOD_RATIO_RESET;
            r_mod_index <= MOD_INDEX_RESET;
            r_cstep     <= '0;
            r_mstep     <= '0;
            r_cphase    <= '0;
            r_mphase    <= '0;
            r_playing   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MOD_RATIO: r_mod_ratio <= i_cfg_data;
                    CFG_MOD_INDEX: r_mod_index <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                case (i_op)
                    OP_NOTE_ON: begin
                        r_cstep   <= n_cstep;
                        r_mstep   <= n_mstep;
                        r_playing <= 1'b1;
                    end
                    OP_RELEASE, OP_END: begin
                        r_playing <= 1'b0;
                    end
                    OP_TICK: begin
                        if (r_playing) begin
                            r_cphase <= r_cphase + r_cstep;
                            r_mphase <= r_mphase + r_mstep;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_voice = '{
        playing:   r_playing,
        cphase:    r_cphase,
        mphase:    r_mphase,
        mod_index: r_mod_index
    };

endmodule

>>> rtl/fmv_offset.sv
// ----------------------------------------------------------------------------
// FM voice phase offset
// Modulator sine lookup and scaling by the modulation index.
// ----------------------------------------------------------------------------
module fmv_offset import fmv_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ld  i_ld,
    input  t_voice    i_voice,
    output t_stage2   o_s2
);

    localparam int    OPROD_W     = MAG_W + CFG_W;
    localparam t_mtab MTAB        = build_mtab();
    localparam logic [OPROD_W-1:0] INDEX_ROUND = OPROD_W'(1) << (INDEX_FRAC - 1);

    logic [MAG_W:0]        r_me;
    t_phase                r_cph1;
    logic                  r_play1;
    t_stage2               r_s2;

    logic [OPROD_W-1:0]    w_prod;
    logic [OPROD_W-1:0]    w_round;

    // Registered read of the modulator table at the current modulator phase.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r_me    <= MTAB[i_voice.mphase[PHASE_BITS-1 -: SINE_AW]];
            r_cph1  <= i_voice.cphase;
            r_play1 <= i_voice.playing;
        end
    end

    always_comb begin
        w_prod  = OPROD_W'(r_me[MAG_W-1:0]) * OPROD_W'(i_voice.mod_index);
        w_round = w_prod + INDEX_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld2) begin
            r_s2.play <= r_play1;
            r_s2.neg  <= r_me[MAG_W];
            r_s2.off  <= w_round[PHASE_BITS+INDEX_FRAC-1:INDEX_FRAC];
            r_s2.cph  <= r_cph1;
        end
    end

    assign o_s2 = r_s2;

endmodule

>>> rtl/fmv_carrier.sv
// ----------------------------------------------------------------------------
// FM voice carrier
// Offset phase sum and carrier sine lookup into the output register.
// ----------------------------------------------------------------------------
module fmv_carrier import fmv_pkg::*; (
    input  logic                 i_clk,
    input  t_pipe_ld             i_ld,
    input  t_stage2              i_s2,
    output logic [SAMPLE_W-1:0]  o_sample
);

    localparam t_ctab CTAB = build_ctab();

    logic [SAMPLE_W-1:0]  r_sample;
    t_phase               w_off;
    t_phase               w_ph;

    always_comb begin
        w_off = i_s2.neg ? (t_phase'(0) - i_s2.off) : i_s2.off;
        w_ph  = i_s2.cph + w_off;
    end

    // A stopped voice reads as silence.
    always_ff @(posedge i_clk) begin
        if (i_ld.ld3) begin
            r_sample <= i_s2.play ? CTAB[w_ph[PHASE_BITS-1 -: SINE_AW]] : '0;
        end
    end

    assign o_sample = r_sample;

endmodule

>>> verif/fm_two_operator_voice_tb.sv
// ----------------------------------------------------------------------------
// Two-operator FM voice testbench
// Drives note and tick commands into the voice under random flow control on
// both channels. A bit-exact predictor in this file computes the sample of
// every tick, and each sample transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module fm_two_operator_voice_tb;
    import fmv_pkg::*;

    // Cycles the voice may still be busy after its last sample transfer.
    localparam int DRAIN_CYCLES   = 6;
    // Cycles in a row with no transfer on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 1000;
    // Items per random phase, five phases in all.
    localparam int PHASE_ITEMS    = 100;

    localparam longint unsigned PH_MASK    = (64'd1 << PHASE_BITS) - 64'd1;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;
    localparam longint unsigned QTURN_Q40  = 64'd1727108826179;
    localparam longint unsigned TURN_Q30   = 64'd6746518852;

    // Notes 120 to 131 in Hz, unsigned Q16.16; lower octaves are derived by
    // shifting the divisor.
    localparam longint unsigned PITCH_ROM_Q16 [12] = '{
        64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
        64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
        64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
    };

    // Divisors of the nested Taylor series of sine, innermost term first.
    localparam longint unsigned SERIES_DIV [6] = '{
        64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
    };

    logic                        i_clk;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_op        = OP_TICK;
    logic [NOTE_W-1:0]           i_note      = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample;

    fm_two_operator_voice u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_note      (i_note),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predicted voice state and the two wave tables.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]            voice_ratio = MOD_RATIO_RESET;
    logic [CFG_W-1:0]            voice_index = MOD_INDEX_RESET;
    t_phase                      car_phase   = '0;
    t_phase                      mod_phase   = '0;
    t_phase                      car_step    = '0;
    t_phase                      mod_step    = '0;
    logic                        voice_on    = 1'b0;

    logic signed [SAMPLE_W-1:0]  sine_q15 [SINE_DEPTH];
    longint                      sine_in_phase [SINE_DEPTH];

    // Samples predicted for accepted ticks, oldest first.
    logic signed [SAMPLE_W-1:0]  pending_samples [$];

    int  fail_count    = 0;
    int  sent_items    = 0;
    int  idle_cycles   = 0;
    int  stall_left    = 0;
    int  stall_len;
    bit  sender_steady = 1'b0;
    bit  out_free      = 1'b0;
    logic signed [SAMPLE_W-1:0] want_sample;

    // Both tables come from one first-quadrant sine in Q30. The angle is
    // folded by quadrant, the series is evaluated in nested form with
    // truncating steps, and the sign of the quadrant is put back last.
    initial begin : build_wave_tables
        longint unsigned d;
        longint unsigned m;
        longint unsigned r;
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned acc;
        longint unsigned s;
        longint unsigned c;
        longint unsigned p;
        logic            neg;
        int              i;
        int              k;
        d = longint'(SINE_DEPTH);
        for (i = 0; i < SINE_DEPTH; i++) begin
            m = 64'd4 * longint'(i);
            if (m <= d) begin
                r   = m;
                neg = 1'b0;
            end else if (m <= 2 * d) begin
                r   = 2 * d - m;
                neg = 1'b0;
            end else if (m <= 3 * d) begin
                r   = m - 2 * d;
                neg = 1'b1;
            end else begin
                r   = 4 * d - m;
                neg = 1'b1;
            end
            ang = ((r * QTURN_Q40) / d + 64'd512) >> 10;
            sq  = (ang * ang) >> 30;
            acc = ONE_Q30;
            for (k = 0; k < 6; k++) begin
                acc = ONE_Q30 - (((sq * acc) >> 30) / SERIES_DIV[k]);
            end
            s = (ang * acc) >> 30;
            // Carrier table: Q1.15 with the positive peak clamped.
            c = (s + 64'd16384) >> 15;
            if (c > 64'd32767) begin
                c = 64'd32767;
            end
            // Modulator table: the same sine scaled into phase units.
            p = ((s << PHASE_BITS) + TURN_Q30 / 2) / TURN_Q30;
            sine_q15[i]      = neg ? -SAMPLE_W'(c) : SAMPLE_W'(c);
            sine_in_phase[i] = neg ? -longint'(p) : longint'(p);
        end
    end

    // Applies one accepted command to the predicted voice. A tick queues the
    // sample it must produce and, on a playing voice, advances both phase accumulators.
    task automatic advance_voice(input t_op op, input logic [NOTE_W-1:0] note);
        longint unsigned oct;
        longint unsigned cls;
        longint unsigned num;
        longint unsigned den;
        longint unsigned prod;
        longint unsigned mag;
        longint unsigned off;
        longint unsigned ph;
        longint          me;
        int              mi;
        int              ci;
        case (op)
            OP_NOTE_ON: begin
                // Retuning keeps both phases; only the steps change.
                oct      = longint'(note) / 12;
                cls      = longint'(note) % 12;
                num      = PITCH_ROM_Q16[cls] << PHASE_BITS;
                den      = 64'(SAMPLE_RATE) << (26 - oct);
                prod     = (num + den / 2) / den;
                car_step = prod[PHASE_BITS-1:0];
                // The ratio is latched here and only here.
                prod     = (64'(car_step) * 64'(voice_ratio) + 64'd128) >> 8;
                mod_step = (prod > PH_MASK) ? t_phase'(PH_MASK) : prod[PHASE_BITS-1:0];
                voice_on = 1'b1;
            end
            OP_RELEASE, OP_END: begin
                voice_on = 1'b0;
            end
            default: begin
                if (!voice_on) begin
                    // A stopped voice gives silence and its phases hold.
                    pending_samples.push_back('0);
                end else begin
                    mi  = int'((64'(mod_phase) * 64'(SINE_DEPTH)) >> PHASE_BITS);
                    me  = sine_in_phase[mi];
                    mag = (me < 0) ? longint'(-me) : longint'(me);
                    // The index is applied live, rounded on the magnitude.
                    off = (mag * 64'(voice_index) + 64'd2048) >> 12;
                    if (me < 0) begin
                        off = 64'd0 - off;
                    end
                    ph  = (64'(car_phase) + off) & PH_MASK;
                    ci  = int'((ph * 64'(SINE_DEPTH)) >> PHASE_BITS);
                    pending_samples.push_back(sine_q15[ci]);
                    car_phase = car_phase + car_step;
                    mod_phase = mod_phase + mod_step;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Flow control helpers.
    // ------------------------------------------------------------------------

    // Gap or stall length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Note for a note-on: the range ends get a fair share.
    function automatic logic [NOTE_W-1:0] pick_note();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end
        return NOTE_W'($urandom);
    endfunction

    // Offers one command and returns at the edge of its transfer. Valid is
    // left high so that back-to-back commands follow without a gap; it is
    // only lowered at the start of a gap or when the voice is drained.
    task automatic send_item(input t_op op, input logic [NOTE_W-1:0] note);
        int gap;
        gap = sender_steady ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_note     <= note;
        do @(posedge i_clk); while (o_in_stall);
        advance_voice(op, note);
        sent_items++;
    endtask

    task automatic tick_voice(input int n);
        repeat (n) send_item(OP_TICK, NOTE_W'($urandom));
    endtask

    // Stops offering commands until every predicted sample has come out,
    // then lets the pipeline run empty.
    task automatic drain_voice();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the voice drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        drain_voice();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_MOD_RATIO) begin
            voice_ratio = value;
        end else begin
            voice_index = value;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Sample checker and receiver stall pattern.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    $error("sample: expected none, actual %0d", o_sample);
                    fail_count++;
                end else begin
                    want_sample = pending_samples.pop_front();
                    if (o_sample !== want_sample) begin
                        $error("sample: expected %0d, actual %0d", want_sample, o_sample);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!out_free && $urandom_range(0, 99) < 30) begin
                stall_len = idle_len();
                if (stall_len != 0) begin
                    stall_left  <= stall_len - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // The run ends as failed if no transfer happens on either channel for
    // too long; this also covers samples that never arrive.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** fm_two_operator_voice: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // A voice that was never started is silent, and stopping it again does
    // nothing.
    task automatic test_stopped_voice();
        tick_voice(1);
        send_item(OP_RELEASE, '1);
        tick_voice(1);
        send_item(OP_END, '0);
    endtask

    // Lowest and highest note; the second note-on retunes a playing voice
    // and must keep its phases.
    task automatic test_note_range();
        send_item(OP_NOTE_ON, '0);
        tick_voice(2);
        send_item(OP_NOTE_ON, '1);
        tick_voice(2);
    endtask

    // Release and end both silence the voice.
    task automatic test_release_end();
        send_item(OP_RELEASE, 7'd69);
        tick_voice(1);
        send_item(OP_NOTE_ON, 7'd69);
        tick_voice(1);
        send_item(OP_END, 7'd69);
        tick_voice(1);
    endtask

    // A ratio written while a note plays only applies at the next note-on.
    // The full-scale ratio saturates the modulator step, a zero ratio
    // freezes the modulator.
    task automatic test_ratio_latch();
        send_item(OP_NOTE_ON, 7'd60);
        tick_voice(1);
        write_reg(CFG_MOD_RATIO, 16'hFFFF);
        tick_voice(1);
        send_item(OP_NOTE_ON, 7'd60);
        tick_voice(1);
        write_reg(CFG_MOD_RATIO, 16'd0);
        send_item(OP_NOTE_ON, 7'd127);
        tick_voice(1);
    endtask

    // The index is used live: zero gives a plain sine, full scale the
    // widest phase swing.
    task automatic test_index_extremes();
        write_reg(CFG_MOD_RATIO, MOD_RATIO_RESET);
        send_item(OP_NOTE_ON, 7'd90);
        write_reg(CFG_MOD_INDEX, 16'd0);
        tick_voice(2);
        write_reg(CFG_MOD_INDEX, 16'hFFFF);
        tick_voice(2);
    endtask

    // Five phases of random traffic, each under its own register setting.
    // Most traffic is whole notes: note-on, a run of ticks, maybe a retune,
    // a release or end, and a few silent ticks. The rest is raw noise.
    task automatic test_random_voice();
        logic [CFG_W-1:0] ratio_plan [5];
        logic [CFG_W-1:0] index_plan [5];
        int               phase;
        int               start;
        int               r;
        ratio_plan = '{16'd256, 16'd0, 16'hFFFF, CFG_W'($urandom),
                       CFG_W'($urandom_range(128, 1024))};
        index_plan = '{16'd4096, 16'hFFFF, 16'd0, CFG_W'($urandom),
                       CFG_W'($urandom_range(0, 16384))};
        for (phase = 0; phase < 5; phase++) begin
            write_reg(CFG_MOD_RATIO, ratio_plan[phase]);
            write_reg(CFG_MOD_INDEX, index_plan[phase]);
            // One phase runs at full rate with no stalls on either side.
            sender_steady = (phase == 3);
            out_free      = (phase == 3);
            start         = sent_items;
            while (sent_items - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_item(OP_NOTE_ON, pick_note());
                    tick_voice($urandom_range(1, 24));
                    if ($urandom_range(0, 99) < 25) begin
                        send_item(OP_NOTE_ON, pick_note());
                        tick_voice($urandom_range(1, 12));
                    end
                    send_item($urandom_range(0, 1) ? OP_RELEASE : OP_END,
                              NOTE_W'($urandom));
                    tick_voice($urandom_range(0, 2));
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(t_op'($urandom_range(0, 3)), NOTE_W'($urandom));
                    end
                end
                // Now and then the sender waits for every sample to come back.
                if ($urandom_range(0, 99) < 5) begin
                    drain_voice();
                end
            end
        end
        sender_steady = 1'b0;
        out_free      = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stopped_voice();
        test_note_range();
        test_release_end();
        test_ratio_latch();
        test_index_extremes();
        test_random_voice();
        drain_voice();
        if (fail_count == 0) begin
            $display("** fm_two_operator_voice: PASSED **");
        end else begin
            $display("** fm_two_operator_voice: FAILED **");
        end
        $finish;
    end

endmodule
